FILE: src/assert_macros.svh
// Assertion macros for the top-level RTL file of the UYVY to RGB converter.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/uyvy_pkg.sv
// Shared constants, types and the channel clamp for the UYVY to RGB converter.
// No dependencies.
package uyvy_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned OffW  = 9;   // signed Y-16, Cb-128, Cr-128
  localparam int unsigned CoefW = 13;  // signed Q10 coefficients
  localparam int unsigned ProdW = OffW + CoefW;
  localparam int unsigned SumW  = 21;  // every channel sum fits here

  localparam logic signed [CoefW-1:0] K_Y  = 13'sd1192;
  localparam logic signed [CoefW-1:0] K_BU = 13'sd2066;
  localparam logic signed [CoefW-1:0] K_GV = 13'sd833;
  localparam logic signed [CoefW-1:0] K_GU = 13'sd400;
  localparam logic signed [CoefW-1:0] K_RV = 13'sd1634;

  localparam logic [OffW-1:0] LumaOffset   = 9'd16;
  localparam logic [OffW-1:0] ChromaOffset = 9'd128;
  localparam logic [ByteW-1:0] ChanMax     = 8'd255;

  // Load enables for pipeline stages two to four.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Floor divide by 1024 and clamp to 0..255.
  function automatic logic [ByteW-1:0] clamp_chan(input logic signed [SumW-1:0] sum);
    logic [ByteW-1:0] res;
    if (sum[SumW-1]) begin
      res = '0;
    end else if (|sum[SumW-2:18]) begin
      res = ChanMax;
    end else begin
      res = sum[17:10];
    end
    return res;
  endfunction

endpackage

FILE: src/uyvy_pixel_dp.sv
// Per-pixel datapath: luma product, channel sums and clamps (stages two to four).
// Depends on uyvy_pkg.
module uyvy_pixel_dp (
  input  logic                                 clk_i,
  input  uyvy_pkg::stage_en_t                  en_i,
  input  logic signed [uyvy_pkg::OffW-1:0]     y_off_i,
  input  logic signed [uyvy_pkg::SumW-1:0]     rv_i,
  input  logic signed [uyvy_pkg::SumW-1:0]     gv_i,
  input  logic signed [uyvy_pkg::SumW-1:0]     gu_i,
  input  logic signed [uyvy_pkg::SumW-1:0]     bu_i,
  output logic [uyvy_pkg::ByteW-1:0]           red_o,
  output logic [uyvy_pkg::ByteW-1:0]           green_o,
  output logic [uyvy_pkg::ByteW-1:0]           blue_o
);

  logic signed [uyvy_pkg::ProdW-1:0] yt_full;
  logic signed [uyvy_pkg::SumW-1:0]  yt_d, yt_q;
  logic signed [uyvy_pkg::SumW-1:0]  r_sum_d, r_sum_q, g_sum_d, g_sum_q, b_sum_d, b_sum_q;
  logic [uyvy_pkg::ByteW-1:0]        red_q, green_q, blue_q;

  always_comb begin
    yt_full = y_off_i * uyvy_pkg::K_Y;
    yt_d    = yt_full[uyvy_pkg::SumW-1:0];
    r_sum_d = yt_q + rv_i;
    g_sum_d = yt_q - gv_i - gu_i;
    b_sum_d = yt_q + bu_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      yt_q <= yt_d;
    end
    if (en_i.s3) begin
      r_sum_q <= r_sum_d;
      g_sum_q <= g_sum_d;
      b_sum_q <= b_sum_d;
    end
    if (en_i.s4) begin
      red_q   <= uyvy_pkg::clamp_chan(r_sum_q);
      green_q <= uyvy_pkg::clamp_chan(g_sum_q);
      blue_q  <= uyvy_pkg::clamp_chan(b_sum_q);
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

FILE: src/uyvy_to_rgb_converter_core.sv
// UYVY to RGB converter, top level: handshake, offsets, chroma products, two pixel paths.
// Depends on uyvy_pkg, uyvy_pixel_dp and assert_macros.svh.
//
// The block takes one UYVY macropixel per transaction and returns two BT.601
// studio-range RGB pixels that share its chroma, one result transaction for
// each input transaction, in order. It accepts a new macropixel in every
// clock cycle while the output side is ready. The work runs through four
// register stages: offset removal, the Q10 multiplies, the channel sums, and
// the divide-by-1024 with clamp to 0..255, whose register is also the output
// register. When the output stalls, each stage holds its item and empty
// stages still fill, so the input keeps taking transactions until all four
// stages hold data. The frame-end flag travels with its macropixel to tlast.
`include "assert_macros.svh"

module uyvy_to_rgb_converter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // From bit 0: chroma_blue[7:0], luma_first[15:8], chroma_red[23:16], luma_second[31:24].
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_in_frame
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // From bit 0: red_first, green_first, blue_first, red_second, green_second,
  // blue_second, eight bits each.
  output logic [47:0] m_axis_tdata,
  output logic        m_axis_tlast    // frame_end
);

  localparam int unsigned OffW = uyvy_pkg::OffW;
  localparam int unsigned SumW = uyvy_pkg::SumW;

  // Stage valids and advance terms. A stage may load when it is empty or
  // when the stage after it is moving on.
  logic v1_q, v2_q, v3_q, v4_q;
  logic adv1, adv2, adv3, adv4;
  uyvy_pkg::stage_en_t en;

  assign adv4 = !v4_q || m_axis_tready;
  assign adv3 = !v3_q || adv4;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign en.s2 = adv2;
  assign en.s3 = adv3;
  assign en.s4 = adv4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (adv4) v4_q <= v3_q;
    end
  end

  // Stage one: remove the luma and chroma offsets.
  logic signed [OffW-1:0] y0_off_d, y0_off_q, y1_off_d, y1_off_q, u_d, u_q, v_d, v_q;
  logic                   last1_q, last2_q, last3_q, last4_q;

  assign u_d      = $signed({1'b0, s_axis_tdata[7:0]})   - $signed(uyvy_pkg::ChromaOffset);
  assign y0_off_d = $signed({1'b0, s_axis_tdata[15:8]})  - $signed(uyvy_pkg::LumaOffset);
  assign v_d      = $signed({1'b0, s_axis_tdata[23:16]}) - $signed(uyvy_pkg::ChromaOffset);
  assign y1_off_d = $signed({1'b0, s_axis_tdata[31:24]}) - $signed(uyvy_pkg::LumaOffset);

  // Stage two: chroma products, shared by both pixels.
  logic signed [uyvy_pkg::ProdW-1:0] rv_full, gv_full, gu_full, bu_full;
  logic signed [SumW-1:0]            rv_q, gv_q, gu_q, bu_q;

  always_comb begin
    rv_full = v_q * uyvy_pkg::K_RV;
    gv_full = v_q * uyvy_pkg::K_GV;
    gu_full = u_q * uyvy_pkg::K_GU;
    bu_full = u_q * uyvy_pkg::K_BU;
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      u_q      <= u_d;
      v_q      <= v_d;
      y0_off_q <= y0_off_d;
      y1_off_q <= y1_off_d;
      last1_q  <= s_axis_tlast;
    end
    if (adv2) begin
      rv_q    <= rv_full[SumW-1:0];
      gv_q    <= gv_full[SumW-1:0];
      gu_q    <= gu_full[SumW-1:0];
      bu_q    <= bu_full[SumW-1:0];
      last2_q <= last1_q;
    end
    if (adv3) last3_q <= last2_q;
    if (adv4) last4_q <= last3_q;
  end

  // Stages two to four of each pixel: luma product, sums and clamps.
  logic [7:0] r0, g0, b0, r1, g1, b1;

  uyvy_pixel_dp u_pix_first (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_off_i (y0_off_q),
    .rv_i    (rv_q),
    .gv_i    (gv_q),
    .gu_i    (gu_q),
    .bu_i    (bu_q),
    .red_o   (r0),
    .green_o (g0),
    .blue_o  (b0)
  );

  uyvy_pixel_dp u_pix_second (
    .clk_i   (clk_i),
    .en_i    (en),
    .y_off_i (y1_off_q),
    .rv_i    (rv_q),
    .gv_i    (gv_q),
    .gu_i    (gu_q),
    .bu_i    (bu_q),
    .red_o   (r1),
    .green_o (g1),
    .blue_o  (b1)
  );

  assign s_axis_tready = adv1;
  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {b1, g1, r1, b0, g0, r0};
  assign m_axis_tlast  = last4_q;

  // A ready output drains the pipeline, so the input must be open too.
  `ASSERT_RST(a_ready_passes, clk_i, rst_ni, m_axis_tready |-> s_axis_tready,
              "input stalled while output is ready")
  // A result can only appear when stage three held an item.
  `ASSERT_RST(a_out_from_s3, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(v3_q),
              "output valid without an item in stage three")
  // A blocked stage three keeps its item and its frame-end flag.
  `ASSERT_RST(a_s3_holds, clk_i, rst_ni, (v3_q && !adv4) |=> (v3_q && $stable(last3_q)),
              "stage three lost its item during a stall")

endmodule
